// ===== sv/fcr_pkg.sv =====
// ----------------------------------------------------------------------------
// fcr_pkg
// Types and constants shared by the framed command receiver and its lanes.
// ----------------------------------------------------------------------------
package fcr_pkg;

  localparam logic [7:0] FRAME_MARK   = 8'hA5;
  localparam logic [7:0] CMD_LED      = 8'h01;
  localparam logic [7:0] CMD_BUZZER   = 8'h02;
  localparam logic [7:0] CMD_SET_TIME = 8'h03;
  localparam logic [7:0] APPLY_FLAG   = 8'h01;
  localparam logic [7:0] SEC_MIN_LAST = 8'd59;
  localparam logic [7:0] HOUR_LAST    = 8'd23;

  localparam logic [7:0] HOUR_RESET   = 8'd10;
  localparam logic [7:0] MINUTE_RESET = 8'd55;
  localparam logic [7:0] SECOND_RESET = 8'd30;

  localparam logic [2:0] REPLY_NONE     = 3'd0;
  localparam logic [2:0] REPLY_LED_ON   = 3'd1;
  localparam logic [2:0] REPLY_LED_OFF  = 3'd2;
  localparam logic [2:0] REPLY_BEEP_ON  = 3'd3;
  localparam logic [2:0] REPLY_BEEP_OFF = 3'd4;
  localparam logic [2:0] REPLY_TIME_SET = 3'd5;

  typedef struct packed {
    logic [7:0] hour;
    logic [7:0] minute;
    logic [7:0] second;
  } tod_t;

  // What the frame lane found in one command beat.
  typedef struct packed {
    logic ok;
    logic cmd_led;
    logic cmd_buzzer;
    logic cmd_time;
    logic apply;
  } frame_res_t;

endpackage

// ===== sv/fcr_frame_lane.sv =====
// ----------------------------------------------------------------------------
// fcr_frame_lane
// Checks header, trailer and checksum of one frame and decodes its command.
// ----------------------------------------------------------------------------
module fcr_frame_lane import fcr_pkg::*; (
  input  logic [7:0]  byte_0,
  input  logic [7:0]  byte_1,
  input  logic [7:0]  byte_2,
  input  logic [7:0]  byte_3,
  input  logic [7:0]  byte_4,
  input  logic [7:0]  byte_5,
  input  logic [7:0]  byte_6,
  input  logic [7:0]  byte_7,
  output frame_res_t  res
);

  logic [7:0] sum;

  assign sum = byte_1 + byte_2 + byte_3 + byte_4 + byte_5;

  always_comb begin
    res.ok         = (byte_0 == FRAME_MARK) && (byte_7 == FRAME_MARK) && (byte_6 == sum);
    res.cmd_led    = (byte_1 == CMD_LED);
    res.cmd_buzzer = (byte_1 == CMD_BUZZER);
    res.cmd_time   = (byte_1 == CMD_SET_TIME);
    res.apply      = (byte_5 == APPLY_FLAG);
  end

endmodule

// ===== sv/fcr_tick_lane.sv =====
// ----------------------------------------------------------------------------
// fcr_tick_lane
// Computes the time of day one second after the given time.
// ----------------------------------------------------------------------------
module fcr_tick_lane import fcr_pkg::*; (
  input  tod_t now,
  output tod_t next
);

  always_comb begin
    next = now;
    // Carries happen only on exact equality, so out-of-range counts just wrap at 256.
    if (now.second == SEC_MIN_LAST) begin
      next.second = '0;
      if (now.minute == SEC_MIN_LAST) begin
        next.minute = '0;
        if (now.hour == HOUR_LAST) begin
          next.hour = '0;
        end else begin
          next.hour = now.hour + 8'd1;
        end
      end else begin
        next.minute = now.minute + 8'd1;
      end
    end else begin
      next.second = now.second + 8'd1;
    end
  end

endmodule

// ===== sv/framed_command_receiver_clock.sv =====
// ----------------------------------------------------------------------------
// framed_command_receiver_clock
// Framed command receiver with LED, buzzer and time-of-day clock.
// ----------------------------------------------------------------------------
// Each input beat carries either a one-second tick (in_item_kind = 1) or a
// whole 8-byte command frame (in_item_kind = 0). A frame lane and a tick lane
// evaluate the beat side by side; a merge stage picks the new state and
// reply. Each input beat yields exactly one output beat showing frame
// validity, the reply code and the device and clock state after the beat.
// The result sits in the output register on the cycle after the input beat is
// accepted. Throughput is one beat per cycle while out_stall stays low, set by
// the single output register that the receiver drains.
// While the output register holds an untaken result and out_stall is high,
// in_stall is high and nothing new is accepted; the held result stays put.
// Synchronous reset (rst_n low) sets LED and buzzer off and the clock to
// 10:55:30, empties the output register and holds in_stall high.
// ----------------------------------------------------------------------------
module framed_command_receiver_clock import fcr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_item_kind,
  input  logic [7:0] in_frame_byte_0,
  input  logic [7:0] in_frame_byte_1,
  input  logic [7:0] in_frame_byte_2,
  input  logic [7:0] in_frame_byte_3,
  input  logic [7:0] in_frame_byte_4,
  input  logic [7:0] in_frame_byte_5,
  input  logic [7:0] in_frame_byte_6,
  input  logic [7:0] in_frame_byte_7,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_frame_ok,
  output logic [2:0] out_reply_code,
  output logic       out_led_lit,
  output logic       out_buzzer_on,
  output logic [7:0] out_hour_now,
  output logic [7:0] out_minute_now,
  output logic [7:0] out_second_now
);

  logic       led_r, led_nxt;
  logic       buzzer_r, buzzer_nxt;
  tod_t       tod_r, tod_nxt;
  tod_t       tod_tick;
  frame_res_t frame_res;
  logic       ok_nxt;
  logic [2:0] reply_nxt;
  logic       accept;

  logic       out_valid_r;
  logic       out_ok_r;
  logic [2:0] out_reply_r;
  logic       out_led_r;
  logic       out_buzzer_r;
  tod_t       out_tod_r;

  fcr_frame_lane u_frame_lane (
    .byte_0 (in_frame_byte_0),
    .byte_1 (in_frame_byte_1),
    .byte_2 (in_frame_byte_2),
    .byte_3 (in_frame_byte_3),
    .byte_4 (in_frame_byte_4),
    .byte_5 (in_frame_byte_5),
    .byte_6 (in_frame_byte_6),
    .byte_7 (in_frame_byte_7),
    .res    (frame_res)
  );

  fcr_tick_lane u_tick_lane (
    .now  (tod_r),
    .next (tod_tick)
  );

  assign in_stall = !rst_n || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  // Merge stage: combine what the lanes found into the next state and reply.
  always_comb begin
    led_nxt    = led_r;
    buzzer_nxt = buzzer_r;
    tod_nxt    = tod_r;
    ok_nxt     = 1'b0;
    reply_nxt  = REPLY_NONE;
    if (in_item_kind) begin
      tod_nxt = tod_tick;
    end else if (frame_res.ok) begin
      ok_nxt = 1'b1;
      if (frame_res.cmd_led) begin
        led_nxt   = frame_res.apply;
        reply_nxt = frame_res.apply ? REPLY_LED_ON : REPLY_LED_OFF;
      end else if (frame_res.cmd_buzzer) begin
        buzzer_nxt = frame_res.apply;
        reply_nxt  = frame_res.apply ? REPLY_BEEP_ON : REPLY_BEEP_OFF;
      end else if (frame_res.cmd_time && frame_res.apply) begin
        tod_nxt.hour   = in_frame_byte_2;
        tod_nxt.minute = in_frame_byte_3;
        tod_nxt.second = in_frame_byte_4;
        reply_nxt      = REPLY_TIME_SET;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_r       <= 1'b0;
      buzzer_r    <= 1'b0;
      tod_r       <= '{hour: HOUR_RESET, minute: MINUTE_RESET, second: SECOND_RESET};
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        led_r       <= led_nxt;
        buzzer_r    <= buzzer_nxt;
        tod_r       <= tod_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ok_r     <= ok_nxt;
      out_reply_r  <= reply_nxt;
      out_led_r    <= led_nxt;
      out_buzzer_r <= buzzer_nxt;
      out_tod_r    <= tod_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_ok   = out_ok_r;
  assign out_reply_code = out_reply_r;
  assign out_led_lit    = out_led_r;
  assign out_buzzer_on  = out_buzzer_r;
  assign out_hour_now   = out_tod_r.hour;
  assign out_minute_now = out_tod_r.minute;
  assign out_second_now = out_tod_r.second;

  // A result beat always follows an accepted input beat.
  a_accept_yields_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted beat produced no result");

  // A rejected frame or a tick never reports an action.
  a_no_reply_without_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_frame_ok) |-> (out_reply_code == REPLY_NONE))
    else $error("reply code set on a beat that was not a valid frame");

  // The shown LED state only moves when a new beat is taken.
  a_led_holds_without_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(accept)) |-> $stable(out_led_lit))
    else $error("LED state changed without an accepted beat");

  // The output reflects the device state registers.
  a_led_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_led_lit == led_r && out_buzzer_on == buzzer_r))
    else $error("output device state differs from internal state");

endmodule

// ===== bench/framed_command_receiver_clock_tb.sv =====
// ----------------------------------------------------------------------------
// framed_command_receiver_clock_tb
// Self-checking bench for the framed command receiver and its clock.
// ----------------------------------------------------------------------------
// Directed beats cover the clock carries (including counters loaded out of
// range), the LED and buzzer commands, rejected frames and commands that are
// ignored. Random traffic follows, mostly well-formed frames and ticks, and the
// rest broken frames. A local model of the device and clock state predicts
// every output beat, and a monitor compares each one field by field. Both
// sides idle at random, and one long output hold-off fills the block.
// ----------------------------------------------------------------------------
module framed_command_receiver_clock_tb;
  import fcr_pkg::*;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  localparam int HOLD_LEN     = 150;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic            kind;
    logic [7:0][7:0] frame;  // frame[0] is the header, frame[7] the trailer
  } cmd_item_t;

  typedef struct packed {
    logic       frame_ok;
    logic [2:0] reply;
    logic       led;
    logic       buzzer;
    tod_t       tod;
  } status_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic       in_item_kind;
  logic [7:0] in_frame_byte_0;
  logic [7:0] in_frame_byte_1;
  logic [7:0] in_frame_byte_2;
  logic [7:0] in_frame_byte_3;
  logic [7:0] in_frame_byte_4;
  logic [7:0] in_frame_byte_5;
  logic [7:0] in_frame_byte_6;
  logic [7:0] in_frame_byte_7;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_frame_ok;
  logic [2:0] out_reply_code;
  logic       out_led_lit;
  logic       out_buzzer_on;
  logic [7:0] out_hour_now;
  logic [7:0] out_minute_now;
  logic [7:0] out_second_now;

  // Model of the receiver state.
  logic led_model;
  logic buzzer_model;
  tod_t clock_model;

  status_t     status_q[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_on = 1'b0;
  int unsigned hold_cycles = 0;

  framed_command_receiver_clock u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_item_kind    (in_item_kind),
    .in_frame_byte_0 (in_frame_byte_0),
    .in_frame_byte_1 (in_frame_byte_1),
    .in_frame_byte_2 (in_frame_byte_2),
    .in_frame_byte_3 (in_frame_byte_3),
    .in_frame_byte_4 (in_frame_byte_4),
    .in_frame_byte_5 (in_frame_byte_5),
    .in_frame_byte_6 (in_frame_byte_6),
    .in_frame_byte_7 (in_frame_byte_7),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_frame_ok    (out_frame_ok),
    .out_reply_code  (out_reply_code),
    .out_led_lit     (out_led_lit),
    .out_buzzer_on   (out_buzzer_on),
    .out_hour_now    (out_hour_now),
    .out_minute_now  (out_minute_now),
    .out_second_now  (out_second_now)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("framed_command_receiver_clock_tb NOT OK");
      $finish;
    end
  end

  // Receiver side: random stalls, overridden once by a long hold-off.
  always @(negedge clk) begin
    if (hold_on && hold_cycles < HOLD_LEN) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  function automatic cmd_item_t frame_item(input logic [7:0] cmd, input logic [7:0] hh,
                                           input logic [7:0] mm, input logic [7:0] ss,
                                           input logic [7:0] flag);
    cmd_item_t it;
    it.kind     = KIND_FRAME;
    it.frame[0] = FRAME_MARK;
    it.frame[1] = cmd;
    it.frame[2] = hh;
    it.frame[3] = mm;
    it.frame[4] = ss;
    it.frame[5] = flag;
    it.frame[6] = cmd + hh + mm + ss + flag;
    it.frame[7] = FRAME_MARK;
    return it;
  endfunction

  function automatic cmd_item_t tick_item(input logic [63:0] junk);
    cmd_item_t it;
    it.kind  = KIND_TICK;
    it.frame = junk;
    return it;
  endfunction

  function automatic logic [7:0] pick_count(input logic [7:0] last);
    case ($urandom_range(3))
      0: return last;
      1: return last - 8'($urandom_range(2));
      2: return 8'($urandom_range(int'(last)));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic cmd_item_t random_item();
    cmd_item_t   it;
    int unsigned pick;
    logic [7:0]  cmd;
    logic [7:0]  flag;
    pick = $urandom_range(99);
    if (pick < 30) return tick_item({$urandom, $urandom});
    case ($urandom_range(9))
      0, 1, 2: cmd = CMD_LED;
      3, 4, 5: cmd = CMD_BUZZER;
      6, 7, 8: cmd = CMD_SET_TIME;
      default: cmd = 8'($urandom);
    endcase
    case ($urandom_range(3))
      0, 1:    flag = APPLY_FLAG;
      2:       flag = 8'h00;
      default: flag = 8'($urandom);
    endcase
    it = frame_item(cmd, pick_count(HOUR_LAST), pick_count(SEC_MIN_LAST),
                    pick_count(SEC_MIN_LAST), flag);
    // About one beat in seven is a damaged frame.
    if (pick >= 85) begin
      case ($urandom_range(3))
        0: it.frame[0] = it.frame[0] ^ 8'($urandom_range(255, 1));
        1: it.frame[7] = it.frame[7] ^ 8'($urandom_range(255, 1));
        2: it.frame[6] = it.frame[6] ^ 8'($urandom_range(255, 1));
        default: it.frame = {$urandom, $urandom};
      endcase
    end
    return it;
  endfunction

  // Applies one beat to the model and returns the status it must produce.
  function automatic status_t advance_receiver(input cmd_item_t it);
    status_t    st;
    logic [7:0] sum;
    logic       apply;
    st.frame_ok = 1'b0;
    st.reply    = REPLY_NONE;
    if (it.kind == KIND_TICK) begin
      if (clock_model.second == SEC_MIN_LAST) begin
        clock_model.second = 8'd0;
        if (clock_model.minute == SEC_MIN_LAST) begin
          clock_model.minute = 8'd0;
          if (clock_model.hour == HOUR_LAST) clock_model.hour = 8'd0;
          else clock_model.hour = clock_model.hour + 8'd1;
        end else begin
          clock_model.minute = clock_model.minute + 8'd1;
        end
      end else begin
        clock_model.second = clock_model.second + 8'd1;
      end
    end else begin
      sum   = it.frame[1] + it.frame[2] + it.frame[3] + it.frame[4] + it.frame[5];
      apply = (it.frame[5] == APPLY_FLAG);
      if (it.frame[0] == FRAME_MARK && it.frame[7] == FRAME_MARK && it.frame[6] == sum) begin
        st.frame_ok = 1'b1;
        if (it.frame[1] == CMD_LED) begin
          led_model = apply;
          st.reply  = apply ? REPLY_LED_ON : REPLY_LED_OFF;
        end else if (it.frame[1] == CMD_BUZZER) begin
          buzzer_model = apply;
          st.reply     = apply ? REPLY_BEEP_ON : REPLY_BEEP_OFF;
        end else if (it.frame[1] == CMD_SET_TIME && apply) begin
          clock_model.hour   = it.frame[2];
          clock_model.minute = it.frame[3];
          clock_model.second = it.frame[4];
          st.reply           = REPLY_TIME_SET;
        end
      end
    end
    st.led    = led_model;
    st.buzzer = buzzer_model;
    st.tod    = clock_model;
    return st;
  endfunction

  task automatic drive_payload(input cmd_item_t it);
    in_item_kind    <= it.kind;
    in_frame_byte_0 <= it.frame[0];
    in_frame_byte_1 <= it.frame[1];
    in_frame_byte_2 <= it.frame[2];
    in_frame_byte_3 <= it.frame[3];
    in_frame_byte_4 <= it.frame[4];
    in_frame_byte_5 <= it.frame[5];
    in_frame_byte_6 <= it.frame[6];
    in_frame_byte_7 <= it.frame[7];
  endtask

  // Called and returns at a falling edge; the beat stays up until accepted.
  task automatic send_item(input cmd_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      drive_payload(random_item());
      @(negedge clk);
    end
    drive_payload(it);
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    status_q.push_back(advance_receiver(it));
    @(negedge clk);
  endtask

  task automatic report_field(input string field, input logic [7:0] want,
                              input logic [7:0] got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("mismatch in %s: expected %0d, got %0d", field, want, got);
    end
  endtask

  always @(posedge clk) begin : status_monitor
    status_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && !out_stall) begin
      if (status_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("output beat with nothing expected");
      end else begin
        want = status_q.pop_front();
        report_field("frame_ok", 8'(want.frame_ok), 8'(out_frame_ok));
        report_field("reply_code", 8'(want.reply), 8'(out_reply_code));
        report_field("led_lit", 8'(want.led), 8'(out_led_lit));
        report_field("buzzer_on", 8'(want.buzzer), 8'(out_buzzer_on));
        report_field("hour_now", want.tod.hour, out_hour_now);
        report_field("minute_now", want.tod.minute, out_minute_now);
        report_field("second_now", want.tod.second, out_second_now);
      end
    end
  end

  task automatic test_clock_wraps();
    send_item(tick_item(64'd0));
    send_item(frame_item(CMD_SET_TIME, HOUR_LAST, SEC_MIN_LAST, SEC_MIN_LAST, APPLY_FLAG));
    send_item(tick_item(64'd0));
    send_item(frame_item(CMD_SET_TIME, 8'd10, SEC_MIN_LAST, SEC_MIN_LAST, APPLY_FLAG));
    send_item(tick_item({8{8'hFF}}));
    // Counters loaded out of range only carry at the exact wrap values.
    send_item(frame_item(CMD_SET_TIME, 8'hFF, 8'hFF, 8'hFF, APPLY_FLAG));
    send_item(tick_item(64'd0));
    send_item(frame_item(CMD_SET_TIME, 8'hFF, SEC_MIN_LAST, SEC_MIN_LAST, APPLY_FLAG));
    send_item(tick_item(64'd0));
  endtask

  task automatic test_device_commands();
    send_item(frame_item(CMD_LED, 8'd0, 8'd0, 8'd0, APPLY_FLAG));
    send_item(frame_item(CMD_LED, 8'd0, 8'd0, 8'd0, 8'h00));
    send_item(frame_item(CMD_LED, 8'hFF, 8'hFF, 8'hFF, APPLY_FLAG));
    send_item(frame_item(CMD_LED, 8'd0, 8'd0, 8'd0, 8'hFF));
    send_item(frame_item(CMD_BUZZER, 8'd0, 8'd0, 8'd0, APPLY_FLAG));
    send_item(frame_item(CMD_BUZZER, 8'h80, 8'h40, 8'h20, 8'h02));
  endtask

  task automatic test_frame_rejects();
    cmd_item_t it;
    it = frame_item(CMD_LED, 8'd0, 8'd0, 8'd0, APPLY_FLAG);
    it.frame[0] = 8'hA4;
    send_item(it);
    it = frame_item(CMD_LED, 8'd0, 8'd0, 8'd0, APPLY_FLAG);
    it.frame[7] = 8'h5A;
    send_item(it);
    it = frame_item(CMD_BUZZER, 8'd0, 8'd0, 8'd0, APPLY_FLAG);
    it.frame[6] = it.frame[6] + 8'd1;
    send_item(it);
    send_item('{kind: KIND_FRAME, frame: {8{8'hFF}}});
    send_item('{kind: KIND_FRAME, frame: 64'd0});
    // A tick carries a well-formed frame that must be ignored.
    it = frame_item(CMD_LED, 8'd0, 8'd0, 8'd0, 8'h00);
    it.kind = KIND_TICK;
    send_item(it);
  endtask

  task automatic test_ignored_commands();
    send_item(frame_item(CMD_SET_TIME, 8'hFF, 8'hFF, 8'hFF, 8'h00));
    send_item(frame_item(8'h00, 8'd1, 8'd2, 8'd3, APPLY_FLAG));
    send_item(frame_item(8'hFF, 8'd4, 8'd5, 8'd6, APPLY_FLAG));
  endtask

  task automatic test_random_traffic(input int unsigned count);
    repeat (count) send_item(random_item());
  endtask

  task automatic test_output_backpressure();
    hold_on = 1'b1;
    repeat (20) send_item(random_item());
    while (hold_cycles < HOLD_LEN) @(negedge clk);
    hold_on = 1'b0;
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    drive_payload('{kind: KIND_FRAME, frame: 64'd0});
    led_model    = 1'b0;
    buzzer_model = 1'b0;
    clock_model  = '{hour: HOUR_RESET, minute: MINUTE_RESET, second: SECOND_RESET};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 9;
    recv_idle_pct = 71;
    test_clock_wraps();
    test_device_commands();
    test_frame_rejects();
    test_ignored_commands();
    test_random_traffic(370);

    send_idle_pct = 71;
    recv_idle_pct = 9;
    test_random_traffic(370);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(360);
    test_output_backpressure();
    test_random_traffic(20);

    in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && status_q.size() == 0) begin
      $display("framed_command_receiver_clock_tb OK");
    end else begin
      $display("framed_command_receiver_clock_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/fcr_pkg.sv
sv/fcr_frame_lane.sv
sv/fcr_tick_lane.sv
sv/framed_command_receiver_clock.sv
bench/framed_command_receiver_clock_tb.sv
